// ===== rtl/core/md5_message_digest_assert.svh =====
// assertion macros for the md5 core
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication
`define MD5_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/md5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

	localparam int unsigned BUF_WORDS = 16;
	localparam int unsigned WORD_W    = 32;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} md5_state_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word index used by a round
	function automatic logic [3:0] word_index(input logic [5:0] rnd);
		logic [3:0] r4;
		logic [3:0] idx;
		r4 = rnd[3:0];
		case (rnd[5:4])
			2'd0: idx = r4;
			2'd1: idx = 4'((r4 << 2) + r4 + 4'd1);
			2'd2: idx = 4'((r4 << 1) + r4 + 4'd5);
			2'd3: idx = 4'((r4 << 3) - r4);
			default: idx = r4;
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/md5_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module md5_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/md5_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module md5_round (
	input  wire logic [5:0]  rnd,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] c,
	input  wire logic [31:0] d,
	input  wire logic [31:0] w,
	output logic      [31:0] b_next
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [4:0]  n;

	always_comb begin
		case (rnd[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = b ^ c ^ d;
		endcase
		sum    = a + f + w + md5_pkg::ROUND_K[rnd];
		n      = md5_pkg::ROT_AMT[{rnd[5:4], rnd[1:0]}];
		rot    = (sum << n) | (sum >> (6'd32 - {1'b0, n}));
		b_next = rot + b;
	end

endmodule
`default_nettype wire

// ===== rtl/core/md5_message_digest.sv =====
// MD5 hasher over a byte stream. Each input transaction carries a message byte (tuser low)
// or a finish request (tuser high); a finish pads the message, returns the 128-bit digest
// as one output transaction with byte 0 in tdata[7:0], and starts a fresh message. A byte
// that does not complete a 64-byte block is absorbed while the core stays ready. A byte
// that completes a block starts the compression: the write, a step to prime the block
// buffer read, 64 rounds through the single round unit at one round per cycle, and a
// step to fold the result into the chaining words. A finish writes the padding bytes,
// compresses each block it completes (one or two), then loads the digest into the
// output register, which waits there until taken while new bytes are already accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_message_digest_assert.svh"
module md5_message_digest (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // data_byte
	input  wire logic         s_axis_tuser,  // req_type
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [127:0] m_axis_tdata   // digest_lo, digest_hi
);

	localparam int unsigned AW = $clog2(md5_pkg::BUF_WORDS);

	md5_pkg::md5_state_t state_q, state_d;

	logic [60:0]  byte_cnt_q;
	logic [63:0]  length_q;
	logic         fin_q;
	logic         first_q;
	logic         len_q;
	logic [23:0]  word_q;
	logic [5:0]   rnd_q;
	logic [31:0]  ca_q, cb_q, cc_q, cd_q;
	logic [31:0]  ra_q, rb_q, rc_q, rd_q;
	logic         m_valid_q;
	logic [127:0] m_data_q;

	logic         absorb;
	logic         is_len;
	logic [7:0]   absorb_byte;
	logic         start_fin;
	logic         load_out;
	logic         out_free;
	logic [5:0]   pos;
	logic [AW-1:0] raddr;
	logic [31:0]  wdata;
	logic [31:0]  w;
	logic [31:0]  b_next;
	logic         ram_we;

	assign pos      = byte_cnt_q[5:0];
	assign out_free = !m_valid_q || m_axis_tready;
	assign wdata    = {absorb_byte, word_q};
	assign ram_we   = absorb && (pos[1:0] == 2'd3);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		absorb        = 1'b0;
		is_len        = 1'b0;
		absorb_byte   = s_axis_tdata;
		start_fin     = 1'b0;
		load_out      = 1'b0;
		raddr         = md5_pkg::word_index(6'(rnd_q + 6'd1));
		case (state_q)
			md5_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser) begin
						start_fin = 1'b1;
						state_d   = md5_pkg::ST_PAD;
					end else begin
						absorb = 1'b1;
						if (pos == md5_pkg::LAST_POS) begin
							state_d = md5_pkg::ST_LOAD;
						end
					end
				end
			end
			md5_pkg::ST_PAD: begin
				absorb = 1'b1;
				is_len = !first_q && (len_q || pos == md5_pkg::LEN_POS);
				if (first_q) begin
					absorb_byte = md5_pkg::PAD_BYTE;
				end else if (is_len) begin
					absorb_byte = length_q[{pos[2:0], 3'b000} +: 8];
				end else begin
					absorb_byte = 8'h00;
				end
				if (pos == md5_pkg::LAST_POS) begin
					state_d = md5_pkg::ST_LOAD;
				end
			end
			md5_pkg::ST_LOAD: begin
				raddr   = md5_pkg::word_index(6'd0);
				state_d = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_ROUND: begin
				if (rnd_q == md5_pkg::LAST_ROUND) begin
					state_d = md5_pkg::ST_ADD;
				end
			end
			md5_pkg::ST_ADD: begin
				if (!fin_q) begin
					state_d = md5_pkg::ST_IDLE;
				end else if (len_q) begin
					state_d = md5_pkg::ST_EMIT;
				end else begin
					state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters, flags and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			fin_q      <= 1'b0;
			first_q    <= 1'b0;
			len_q      <= 1'b0;
			rnd_q      <= '0;
			ca_q       <= md5_pkg::INIT_A;
			cb_q       <= md5_pkg::INIT_B;
			cc_q       <= md5_pkg::INIT_C;
			cd_q       <= md5_pkg::INIT_D;
			m_valid_q  <= 1'b0;
		end else begin
			if (absorb) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end
			if (start_fin) begin
				fin_q   <= 1'b1;
				first_q <= 1'b1;
			end
			if (state_q == md5_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (is_len) begin
					len_q <= 1'b1;
				end
			end
			if (state_q == md5_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == md5_pkg::ST_ADD) begin
				ca_q <= ca_q + ra_q;
				cb_q <= cb_q + rb_q;
				cc_q <= cc_q + rc_q;
				cd_q <= cd_q + rd_q;
			end
			if (load_out) begin
				byte_cnt_q <= '0;
				fin_q      <= 1'b0;
				len_q      <= 1'b0;
				ca_q       <= md5_pkg::INIT_A;
				cb_q       <= md5_pkg::INIT_B;
				cc_q       <= md5_pkg::INIT_C;
				cd_q       <= md5_pkg::INIT_D;
				m_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start_fin) begin
			length_q <= {byte_cnt_q, 3'b000};
		end
		if (absorb) begin
			word_q[{pos[1:0], 3'b000} +: 8] <= absorb_byte;
		end
		if (state_q == md5_pkg::ST_LOAD) begin
			ra_q <= ca_q;
			rb_q <= cb_q;
			rc_q <= cc_q;
			rd_q <= cd_q;
		end else if (state_q == md5_pkg::ST_ROUND) begin
			ra_q <= rd_q;
			rd_q <= rc_q;
			rc_q <= rb_q;
			rb_q <= b_next;
		end
		if (load_out) begin
			m_data_q <= {cd_q, cc_q, cb_q, ca_q};
		end
	end

	// last byte of a word sits in the top lane of the write data
	md5_ram #(
		.WIDTH(md5_pkg::WORD_W),
		.DEPTH(md5_pkg::BUF_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos[5:2]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(w)
	);

	md5_round u_round (
		.rnd   (rnd_q),
		.a     (ra_q),
		.b     (rb_q),
		.c     (rc_q),
		.d     (rd_q),
		.w     (w),
		.b_next(b_next)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`MD5_ASSERT_NEXT(a_round_end, state_q == md5_pkg::ST_ROUND && rnd_q == md5_pkg::LAST_ROUND, state_q == md5_pkg::ST_ADD && rnd_q == 6'd0, "round counter out of step")
	`MD5_ASSERT_NOW(a_buf_write, ram_we, state_q == md5_pkg::ST_IDLE || state_q == md5_pkg::ST_PAD, "buffer written outside absorb")
	`MD5_ASSERT_NEXT(a_emit, load_out, m_axis_tvalid && byte_cnt_q == 61'd0 && !fin_q, "digest not presented or state not restored")
	`MD5_ASSERT_NOW(a_busy, state_q == md5_pkg::ST_ROUND || state_q == md5_pkg::ST_PAD, !s_axis_tready, "input taken while busy")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [5:0] LEN_SLOT     = 6'd56;
	localparam logic [5:0] BLOCK_END    = 6'd63;
	localparam int         QUIET_TAIL   = 60;
	localparam int         HOLD_CYCLES  = 2500;
	localparam int         HOLD_AT_ITEM = 80;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROT_SH [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	typedef struct packed {
		logic       req;
		logic [7:0] data;
	} hash_item_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} digest_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;  // data_byte
	logic         s_axis_tuser = 1'b0;   // req_type
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;          // digest_lo, digest_hi

	hash_item_t feed_q [$];
	digest_t    digest_q [$];

	logic [31:0] md5_chain [4];
	logic [63:0] md5_bit_len;
	logic [7:0]  md5_block [64];

	int   taken_cnt = 0;
	logic calm = 1'b0;
	int   src_gap = 0;
	int   snk_gap = 0;
	int   hold_cnt = 0;
	logic hold_used = 1'b0;
	int   fault_cnt = 0;

	md5_message_digest u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void md5_restart();
		md5_chain[0] = 32'h67452301;
		md5_chain[1] = 32'hefcdab89;
		md5_chain[2] = 32'h98badcfe;
		md5_chain[3] = 32'h10325476;
		md5_bit_len  = '0;
	endfunction

	// store one byte, compress once the block is full
	function automatic void md5_absorb(logic [7:0] x);
		logic [5:0]  pos;
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int          g;
		pos = md5_bit_len[8:3];
		md5_block[pos] = x;
		md5_bit_len = md5_bit_len + 64'd8;
		if (pos == BLOCK_END) begin
			for (int i = 0; i < 16; i++)
				w[i] = {md5_block[4*i+3], md5_block[4*i+2], md5_block[4*i+1], md5_block[4*i]};
			a = md5_chain[0];
			b = md5_chain[1];
			c = md5_chain[2];
			d = md5_chain[3];
			for (int r = 0; r < 64; r++) begin
				case (r / 16)
					0: begin
						f = (b & c) | (~b & d);
						g = r;
					end
					1: begin
						f = (b & d) | (c & ~d);
						g = (5 * r + 1) % 16;
					end
					2: begin
						f = b ^ c ^ d;
						g = (3 * r + 5) % 16;
					end
					default: begin
						f = c ^ (b | ~d);
						g = (7 * r) % 16;
					end
				endcase
				t = a + f + w[g] + SINE_K[r];
				t = ((t << ROT_SH[(r / 16) * 4 + r % 4]) | (t >> (32 - ROT_SH[(r / 16) * 4 + r % 4])))
					+ b;
				a = d;
				d = c;
				c = b;
				b = t;
			end
			md5_chain[0] = md5_chain[0] + a;
			md5_chain[1] = md5_chain[1] + b;
			md5_chain[2] = md5_chain[2] + c;
			md5_chain[3] = md5_chain[3] + d;
		end
	endfunction

	function automatic void md5_predict(hash_item_t it);
		logic [63:0] len;
		if (it.req == REQ_BYTE) begin
			md5_absorb(it.data);
		end else begin
			len = md5_bit_len;
			md5_absorb(PAD_MARK);
			while (md5_bit_len[8:3] != LEN_SLOT)
				md5_absorb(8'h00);
			for (int k = 0; k < 8; k++)
				md5_absorb(len[8*k +: 8]);
			digest_q.push_back(digest_t'({md5_chain[3], md5_chain[2], md5_chain[1], md5_chain[0]}));
			md5_restart();
		end
	endfunction

	task automatic push_item(logic req, logic [7:0] data);
		hash_item_t it;
		it.req  = req;
		it.data = data;
		feed_q.push_back(it);
	endtask

	task automatic push_message(int len);
		for (int i = 0; i < len; i++)
			push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
		push_item(REQ_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// input side driver
	always @(posedge clk or negedge arst_n) begin
		hash_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tuser  <= REQ_BYTE;
			src_gap = 0;
			md5_restart();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				nxt.req  = s_axis_tuser;
				nxt.data = s_axis_tdata;
				md5_predict(nxt);
				taken_cnt <= taken_cnt + 1;
				if (!calm && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 11);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (feed_q.size() != 0) begin
					nxt = feed_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.data;
					s_axis_tuser  <= nxt.req;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			calm <= (feed_q.size() < QUIET_TAIL);
		end
	end

	// one long hold-off on the output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (!hold_used && taken_cnt >= HOLD_AT_ITEM) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// output side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (snk_gap > 0)
				snk_gap--;
			else if (!calm && $urandom_range(0, 7) == 0)
				snk_gap = $urandom_range(1, 11);
			m_axis_tready <= (snk_gap == 0) && (hold_cnt == 0);
		end
	end

	// digest check per output transaction
	always @(posedge clk) begin
		digest_t got;
		digest_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = digest_t'(m_axis_tdata);
			if (digest_q.size() == 0) begin
				if (fault_cnt < 10)
					$display("tb: digest with none pending: %h", m_axis_tdata);
				fault_cnt++;
			end else begin
				want = digest_q.pop_front();
				if (got.lo !== want.lo) begin
					if (fault_cnt < 10)
						$display("tb: digest_lo exp %h got %h", want.lo, got.lo);
					fault_cnt++;
				end
				if (got.hi !== want.hi) begin
					if (fault_cnt < 10)
						$display("tb: digest_hi exp %h got %h", want.hi, got.hi);
					fault_cnt++;
				end
			end
		end
	end

	initial begin
		int n_msgs;
		int edge_lens [8];
		edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};

		// empty message, single extreme bytes, a short text, mixed bit patterns
		push_item(REQ_FINISH, 8'hff);
		push_item(REQ_BYTE, 8'h00);
		push_item(REQ_FINISH, 8'h00);
		push_item(REQ_BYTE, 8'hff);
		push_item(REQ_FINISH, 8'h5a);
		push_item(REQ_BYTE, 8'h61);
		push_item(REQ_BYTE, 8'h62);
		push_item(REQ_BYTE, 8'h63);
		push_item(REQ_FINISH, 8'ha5);
		push_item(REQ_BYTE, 8'h80);
		push_item(REQ_BYTE, 8'h7f);
		push_item(REQ_BYTE, 8'h01);
		push_item(REQ_BYTE, 8'hfe);
		push_item(REQ_BYTE, 8'h55);
		push_item(REQ_BYTE, 8'haa);
		push_item(REQ_FINISH, 8'h01);
		n_msgs = 5;

		while (feed_q.size() < 450 || n_msgs < 40) begin
			if ($urandom_range(0, 9) == 0)
				push_message(edge_lens[$urandom_range(0, 7)]);
			else
				push_message($urandom_range(0, 10));
			n_msgs++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(feed_q.size() == 0 && !s_axis_tvalid && digest_q.size() == 0))
			@(negedge clk);
		repeat (250) @(negedge clk);

		if (fault_cnt == 0 && digest_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
